// ----- design/kmcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants of the key matrix change detector.
// ----------------------------------------------------------------------------
package kmcd_pkg;

  localparam int MaxRowsDef = 8;
  localparam int MaxColsDef = 8;

  localparam int LevelW   = 8;  // row / column level vectors
  localparam int CntW     = 4;  // row / column count registers
  localparam int RowNumW  = 3;
  localparam int ColNumW  = 3;
  localparam int KeyIdxW  = 6;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 4;

  localparam logic [CfgAddrW-1:0] CfgNumRows = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgNumCols = CfgAddrW'(1);

  localparam logic [CntW-1:0] NumRowsRst = CntW'(8);
  localparam logic [CntW-1:0] NumColsRst = CntW'(8);

  typedef enum logic [2:0] {
    ScanIdle,
    ScanRead,
    ScanCmp,
    ScanEmit,
    ScanDone
  } kmcd_state_e;

  typedef struct packed {
    logic [RowNumW-1:0] row_num;
    logic [ColNumW-1:0] col_num;
    logic [KeyIdxW-1:0] key_index;
    logic               released;
  } kmcd_evt_t;

  // scanner -> event buffer
  typedef struct packed {
    logic      push;   // evt is a new key event
    logic      flush;  // sample finished, mark the held event as last
    kmcd_evt_t evt;
  } kmcd_scan_req_t;

endpackage
`default_nettype wire

// ----- design/kmcd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmcd_if
// Valid/ready channels of the key matrix change detector.
// ----------------------------------------------------------------------------
interface kmcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [kmcd_pkg::LevelW-1:0] row_levels;
  logic [kmcd_pkg::LevelW-1:0] col_levels;

  modport source (output valid, output row_levels, output col_levels, input ready);
  modport sink   (input valid, input row_levels, input col_levels, output ready);
endinterface

interface kmcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [kmcd_pkg::RowNumW-1:0] row_num;
  logic [kmcd_pkg::ColNumW-1:0] col_num;
  logic [kmcd_pkg::KeyIdxW-1:0] key_index;
  logic                         released;
  logic                         last;

  modport source (output valid, output row_num, output col_num, output key_index,
                  output released, output last, input ready);
  modport sink   (input valid, input row_num, input col_num, input key_index,
                  input released, input last, output ready);
endinterface

interface kmcd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kmcd_pkg::CfgAddrW-1:0] addr;
  logic [kmcd_pkg::CfgDataW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ----- design/key_matrix_change_detector_top.sv -----
`default_nettype none
// Path: each event leaves the scanner from the Emit state, then passes the hold register to the output register;
// each event waits in the hold register until the next event or the end of its sample.
// Flow: a new sample is accepted only after the previous one is flushed; each driven row is
// read, compared and written back, and its events leave one per cycle unless stalled.
// Reset: counts return to 8 rows and 8 columns; per-row valid bits make every key read
// as released at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_matrix_change_detector_top
// Reports every key in a driven row and enabled column that changed in a scan sample, one event per transfer.
// ----------------------------------------------------------------------------
module key_matrix_change_detector_top #(
  parameter int MAX_ROWS = kmcd_pkg::MaxRowsDef,
  parameter int MAX_COLS = kmcd_pkg::MaxColsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  kmcd_in_if.sink    in_i,
  kmcd_out_if.source out_o,
  kmcd_cfg_if.sink   cfg_i
);

  localparam int CntW = kmcd_pkg::CntW;

  logic [CntW-1:0] num_rows_q, num_cols_q;

  kmcd_pkg::kmcd_scan_req_t scan_req;
  kmcd_pkg::kmcd_evt_t      hold_evt_q, hold_evt_d;
  kmcd_pkg::kmcd_evt_t      out_evt_q, out_evt_d;
  logic hold_v_q, hold_v_d;
  logic out_v_q, out_v_d;
  logic out_last_q, out_last_d;
  logic out_free, buf_rdy, move;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= kmcd_pkg::NumRowsRst;
      num_cols_q <= kmcd_pkg::NumColsRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == kmcd_pkg::CfgNumRows) begin
        num_rows_q <= CntW'(cfg_i.data);
      end
      if (cfg_i.addr == kmcd_pkg::CfgNumCols) begin
        num_cols_q <= CntW'(cfg_i.data);
      end
    end
  end

  kmcd_scan #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .row_levels_i (in_i.row_levels),
    .col_levels_i (in_i.col_levels),
    .num_rows_i   (num_rows_q),
    .num_cols_i   (num_cols_q),
    .rdy_i        (buf_rdy),
    .req_o        (scan_req)
  );

  // One event is held back so the last one of a sample can be marked.
  always_comb begin
    out_free = !out_v_q || out_o.ready;
    buf_rdy  = !hold_v_q || out_free;
    move     = hold_v_q && buf_rdy && (scan_req.push || scan_req.flush);

    hold_v_d   = hold_v_q;
    hold_evt_d = hold_evt_q;
    if (buf_rdy && scan_req.push) begin
      hold_v_d   = 1'b1;
      hold_evt_d = scan_req.evt;
    end else if (buf_rdy && scan_req.flush) begin
      hold_v_d = 1'b0;
    end

    out_v_d    = out_v_q && !out_o.ready;
    out_evt_d  = out_evt_q;
    out_last_d = out_last_q;
    if (move) begin
      out_v_d    = 1'b1;
      out_evt_d  = hold_evt_q;
      out_last_d = scan_req.flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_evt_q <= hold_evt_d;
    out_evt_q  <= out_evt_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_v_q;
  assign out_o.row_num   = out_evt_q.row_num;
  assign out_o.col_num   = out_evt_q.col_num;
  assign out_o.key_index = out_evt_q.key_index;
  assign out_o.released  = out_evt_q.released;
  assign out_o.last      = out_last_q;

`ifndef NO_ASSERTIONS
  a_hold_empty_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !hold_v_q)
    else $error("new sample accepted while an event is still held");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("event dropped while the receiver stalls");

  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable({out_evt_q, out_last_q}))
    else $error("event changed while the receiver stalls");
`endif

endmodule
`default_nettype wire

// ----- design/kmcd_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmcd_scan
// Row sequencer around the per-row level memory: read, compare, write back,
// then hand out one key event per cycle while the event buffer is ready.
// ----------------------------------------------------------------------------
module kmcd_scan #(
  parameter int MAX_ROWS = kmcd_pkg::MaxRowsDef,
  parameter int MAX_COLS = kmcd_pkg::MaxColsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [kmcd_pkg::LevelW-1:0]   row_levels_i,
  input  wire logic [kmcd_pkg::LevelW-1:0]   col_levels_i,
  input  wire logic [kmcd_pkg::CntW-1:0]     num_rows_i,
  input  wire logic [kmcd_pkg::CntW-1:0]     num_cols_i,
  input  wire logic                          rdy_i,
  output      kmcd_pkg::kmcd_scan_req_t      req_o
);

  localparam int RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LevelW  = kmcd_pkg::LevelW;
  localparam int CntW    = kmcd_pkg::CntW;

  kmcd_pkg::kmcd_state_e state_q, state_d;

  logic [CntW-1:0]   row_q, row_d;
  logic [LevelW-1:0] cin_q, cin_d;
  logic [LevelW-1:0] rowlv_q, rowlv_d;
  logic [LevelW-1:0] chg_q, chg_d;

  logic [LevelW-1:0] mem_q [MAX_ROWS];
  logic [MAX_ROWS-1:0] vld_q;
  logic [LevelW-1:0] rdata_q;
  logic              rvld_q;

  logic [CntW-1:0]    rows_eff, cols_eff;
  logic [LevelW-1:0]  col_mask;
  logic [RowIdxW-1:0] idx;
  logic               row_in_use, driven;
  logic               accept, rd_en, wr_en;
  logic [LevelW-1:0]  old_lv;
  logic [kmcd_pkg::ColNumW-1:0] lo_col;
  logic [6:0]         key_prod;

  assign rows_eff = (num_rows_i > CntW'(MAX_ROWS)) ? CntW'(MAX_ROWS) : num_rows_i;
  assign cols_eff = (num_cols_i > CntW'(MAX_COLS)) ? CntW'(MAX_COLS) : num_cols_i;

  always_comb begin
    for (int c = 0; c < LevelW; c++) begin
      col_mask[c] = (CntW'(c) < cols_eff);
    end
  end

  assign idx        = row_q[RowIdxW-1:0];
  assign row_in_use = (row_q < rows_eff);
  assign driven     = ~rowlv_q[row_q[2:0]];
  assign old_lv     = rvld_q ? rdata_q : {LevelW{1'b1}};

  // lowest changed column
  always_comb begin
    lo_col = '0;
    for (int c = LevelW - 1; c >= 0; c--) begin
      if (chg_q[c]) begin
        lo_col = kmcd_pkg::ColNumW'(c);
      end
    end
  end

  assign key_prod = 7'(row_q[2:0]) * 7'(cols_eff);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kmcd_pkg::ScanIdle: begin
        if (in_valid_i) begin
          state_d = kmcd_pkg::ScanRead;
        end
      end
      kmcd_pkg::ScanRead: begin
        if (!row_in_use) begin
          state_d = kmcd_pkg::ScanDone;
        end else if (driven) begin
          state_d = kmcd_pkg::ScanCmp;
        end
      end
      kmcd_pkg::ScanCmp: state_d = kmcd_pkg::ScanEmit;
      kmcd_pkg::ScanEmit: begin
        if (chg_q == '0) begin
          state_d = kmcd_pkg::ScanRead;
        end
      end
      kmcd_pkg::ScanDone: begin
        if (rdy_i) begin
          state_d = kmcd_pkg::ScanIdle;
        end
      end
      default: state_d = kmcd_pkg::ScanIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o = (state_q == kmcd_pkg::ScanIdle);
    accept     = in_ready_o && in_valid_i;
    rd_en      = (state_q == kmcd_pkg::ScanRead) && row_in_use && driven;
    wr_en      = (state_q == kmcd_pkg::ScanCmp);

    req_o.push          = (state_q == kmcd_pkg::ScanEmit) && (chg_q != '0);
    req_o.flush         = (state_q == kmcd_pkg::ScanDone);
    req_o.evt.row_num   = row_q[2:0];
    req_o.evt.col_num   = lo_col;
    req_o.evt.key_index = kmcd_pkg::KeyIdxW'(key_prod + 7'(lo_col));
    req_o.evt.released  = cin_q[lo_col];

    row_d   = row_q;
    cin_d   = cin_q;
    rowlv_d = rowlv_q;
    chg_d   = chg_q;
    case (state_q)
      kmcd_pkg::ScanIdle: begin
        if (accept) begin
          row_d   = '0;
          cin_d   = col_levels_i;
          rowlv_d = row_levels_i;
        end
      end
      kmcd_pkg::ScanRead: begin
        if (row_in_use && !driven) begin
          row_d = row_q + CntW'(1);
        end
      end
      kmcd_pkg::ScanCmp: chg_d = (old_lv ^ cin_q) & col_mask;
      kmcd_pkg::ScanEmit: begin
        if (chg_q == '0) begin
          row_d = row_q + CntW'(1);
        end else if (rdy_i) begin
          chg_d[lo_col] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmcd_pkg::ScanIdle;
      row_q   <= '0;
      chg_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      chg_q   <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cin_q   <= cin_d;
    rowlv_q <= rowlv_d;
  end

  // level memory, one row per entry
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[idx];
      rvld_q  <= vld_q[idx];
    end
    if (wr_en) begin
      mem_q[idx] <= cin_q;
    end
  end

  // rows never written read as all released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[idx] <= 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_clears_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.push && rdy_i) |=> ($countones(chg_q) + 1 == $countones($past(chg_q))))
    else $error("event transfer did not clear exactly one changed column");

  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == kmcd_pkg::ScanCmp))
    else $error("memory read not followed by compare");

  a_done_past_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kmcd_pkg::ScanDone) |-> (!row_in_use && chg_q == '0))
    else $error("sample finished with rows or events pending");
`endif

endmodule
`default_nettype wire
